>>> hw/rtl/ipv4_dotted_address_parser_macros.svh
// Assertion macros for the IPv4 dotted address parser.
// Used by files that check internal logic; expects clk and arst_n in scope.
`ifndef IPV4_DOTTED_ADDRESS_PARSER_MACROS_SVH
`define IPV4_DOTTED_ADDRESS_PARSER_MACROS_SVH

// Consequence checked in the same cycle as the antecedent.
`define IPV4P_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ipv4 parser check failed");

// Consequence checked in the cycle after the antecedent.
`define IPV4P_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ipv4 parser check failed");

`endif

>>> hw/rtl/ipv4p_pkg.sv
// Shared types and phase codes for the IPv4 dotted address parser.
// No dependencies.
package ipv4p_pkg;

	localparam logic [2:0] PH_START = 3'd0; // start of a part
	localparam logic [2:0] PH_ZERO  = 3'd1; // leading zero seen
	localparam logic [2:0] PH_ZEROX = 3'd2; // "0x" seen, no hex digit yet
	localparam logic [2:0] PH_DEC   = 3'd3;
	localparam logic [2:0] PH_OCT   = 3'd4;
	localparam logic [2:0] PH_HEX   = 3'd5;
	localparam logic [2:0] PH_STOP  = 3'd6; // rest of string ignored
	localparam logic [2:0] PH_FAIL  = 3'd7;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_DOT = 8'h2E;

	typedef struct packed {
		logic [31:0] first_part;
		logic [31:0] second_part;
		logic [31:0] third_part;
		logic [31:0] running_value;
		logic [1:0]  part_count;
		logic [2:0]  parse_phase;
	} parse_state_t;

	// idle parser: no parts, waiting for the first character of a part
	localparam parse_state_t PARSE_RESET = '{
		first_part:    32'd0,
		second_part:   32'd0,
		third_part:    32'd0,
		running_value: 32'd0,
		part_count:    2'd0,
		parse_phase:   PH_START
	};

endpackage

>>> hw/rtl/ipv4p_step.sv
// Next-state logic for one non-terminator character.
// Depends on ipv4p_pkg.
module ipv4p_step (
	input  logic [7:0]              ch,
	input  ipv4p_pkg::parse_state_t cur,
	output ipv4p_pkg::parse_state_t nxt
);

	logic        is_num;
	logic        is_oct;
	logic        is_hex;
	logic [3:0]  digit;
	logic [35:0] prod;
	logic [35:0] sum;
	logic [31:0] acc;
	ipv4p_pkg::parse_state_t ended;

	assign is_num = (ch >= 8'h30) && (ch <= 8'h39);
	assign is_oct = (ch >= 8'h30) && (ch <= 8'h37);
	assign is_hex = is_num || ((ch >= 8'h41) && (ch <= 8'h46)) ||
		((ch >= 8'h61) && (ch <= 8'h66));
	// letters a-f / A-F share low nibble 1..6
	assign digit = is_num ? ch[3:0] : (ch[3:0] + 4'd9);

	// constant-base multiply as shifts and adds
	always_comb begin
		if (cur.parse_phase == ipv4p_pkg::PH_DEC) begin
			prod = {1'b0, cur.running_value, 3'b000} + {3'b000, cur.running_value, 1'b0};
		end else if (cur.parse_phase == ipv4p_pkg::PH_ZERO ||
				cur.parse_phase == ipv4p_pkg::PH_OCT) begin
			prod = {1'b0, cur.running_value, 3'b000};
		end else begin
			prod = {cur.running_value, 4'b0000};
		end
	end

	assign sum = prod + {32'd0, digit};
	assign acc = (|sum[35:32]) ? 32'hFFFF_FFFF : sum[31:0];

	// part ended at a non-digit character
	always_comb begin
		ended = cur;
		if (ch != ipv4p_pkg::CH_DOT || cur.part_count == 2'd3) begin
			ended.parse_phase = ipv4p_pkg::PH_STOP;
		end else begin
			unique case (cur.part_count)
				2'd0: ended.first_part = cur.running_value;
				2'd1: ended.second_part = cur.running_value;
				default: ended.third_part = cur.running_value;
			endcase
			ended.part_count = cur.part_count + 2'd1;
			ended.running_value = 32'd0;
			ended.parse_phase = ipv4p_pkg::PH_START;
		end
	end

	always_comb begin
		nxt = cur;
		unique case (cur.parse_phase)
			ipv4p_pkg::PH_START: begin
				if (ch == 8'h30) begin
					nxt.running_value = 32'd0;
					nxt.parse_phase = ipv4p_pkg::PH_ZERO;
				end else if (is_num) begin
					nxt.running_value = {28'd0, ch[3:0]};
					nxt.parse_phase = ipv4p_pkg::PH_DEC;
				end else begin
					nxt.parse_phase = ipv4p_pkg::PH_FAIL;
				end
			end
			ipv4p_pkg::PH_ZERO: begin
				if (is_oct) begin
					nxt.running_value = acc;
					nxt.parse_phase = ipv4p_pkg::PH_OCT;
				end else if (ch == 8'h78 || ch == 8'h58) begin
					nxt.parse_phase = ipv4p_pkg::PH_ZEROX;
				end else begin
					nxt = ended;
				end
			end
			ipv4p_pkg::PH_ZEROX: begin
				if (is_hex) begin
					nxt.running_value = acc;
					nxt.parse_phase = ipv4p_pkg::PH_HEX;
				end else begin
					nxt.parse_phase = ipv4p_pkg::PH_STOP;
				end
			end
			ipv4p_pkg::PH_DEC: begin
				if (is_num) nxt.running_value = acc;
				else nxt = ended;
			end
			ipv4p_pkg::PH_OCT: begin
				if (is_oct) nxt.running_value = acc;
				else nxt = ended;
			end
			ipv4p_pkg::PH_HEX: begin
				if (is_hex) nxt.running_value = acc;
				else nxt = ended;
			end
			ipv4p_pkg::PH_STOP, ipv4p_pkg::PH_FAIL: begin
				nxt = cur;
			end
		endcase
	end

endmodule

>>> hw/rtl/ipv4p_assemble.sv
// Final address assembly and range check at the terminator.
// Depends on ipv4p_pkg.
module ipv4p_assemble (
	input  ipv4p_pkg::parse_state_t cur,
	output logic                    ok,
	output logic [31:0]             addr
);

	logic        in_range;
	logic [31:0] merged;

	always_comb begin
		unique case (cur.part_count)
			2'd0: begin
				in_range = 1'b1;
				merged = cur.running_value;
			end
			2'd1: begin
				in_range = (cur.running_value <= 32'h00FF_FFFF);
				merged = cur.running_value | {cur.first_part[7:0], 24'd0};
			end
			2'd2: begin
				in_range = (cur.running_value <= 32'h0000_FFFF);
				merged = cur.running_value | {cur.first_part[7:0], 24'd0} |
					{cur.second_part[15:0], 16'd0};
			end
			default: begin
				in_range = (cur.running_value <= 32'h0000_00FF);
				merged = cur.running_value | {cur.first_part[7:0], 24'd0} |
					{cur.second_part[15:0], 16'd0} | {cur.third_part[23:0], 8'd0};
			end
		endcase
	end

	assign ok = in_range && cur.parse_phase != ipv4p_pkg::PH_START &&
		cur.parse_phase != ipv4p_pkg::PH_FAIL;
	assign addr = ok ? merged : 32'd0;

endmodule

>>> hw/rtl/ipv4_dotted_address_parser.sv
// IPv4 dotted address parser (classic BSD address-text style). Text enters
// one character per item; a NUL character ends the string and yields exactly
// one result item: parsed_ok and the host-order address (0 on failure). Other
// characters yield no result. Parts may be decimal, octal (leading 0) or hex
// (0x/0X), saturate at 0xFFFFFFFF, and are assembled as a, a.b, a.b.c or
// a.b.c.d with a range check on the last part only. Throughput is one
// character per cycle: the character is registered, then one pass of
// next-state logic (a shift-add multiply by 8, 10 or 16 on the running
// value) updates the parse state. A result is loaded into the output
// register when its terminator is processed; the output register lets the
// next string's characters keep flowing while a result waits, and only a
// terminator meeting a full, stalled output register holds the input.
// Depends on ipv4p_pkg, ipv4p_step, ipv4p_assemble and the macros header.
`include "ipv4_dotted_address_parser_macros.svh"

module ipv4_dotted_address_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  character,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        parsed_ok,
	output logic [31:0] address
);

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;

	// parse state
	ipv4p_pkg::parse_state_t state_q;
	ipv4p_pkg::parse_state_t state_nxt;

	// result register
	logic        res_valid_q;
	logic        res_ok_q;
	logic [31:0] res_addr_q;

	logic        is_term;
	logic        out_free;
	logic        proc;
	logic        asm_ok;
	logic [31:0] asm_addr;

	assign is_term  = (char_s1 == ipv4p_pkg::CH_NUL);
	assign out_free = !res_valid_q || !result_stall;
	// plain characters never need the output; a terminator needs a free slot
	assign proc       = valid_s1 && (!is_term || out_free);
	assign char_stall = valid_s1 && !proc;

	ipv4p_step u_step (
		.ch  (char_s1),
		.cur (state_q),
		.nxt (state_nxt)
	);

	ipv4p_assemble u_assemble (
		.cur  (state_q),
		.ok   (asm_ok),
		.addr (asm_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipv4p_pkg::PARSE_RESET;
		end else if (proc) begin
			if (is_term) begin
				// string done: back to the reset state for the next one
				state_q <= ipv4p_pkg::PARSE_RESET;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc && is_term) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && is_term) begin
			res_ok_q   <= asm_ok;
			res_addr_q <= asm_addr;
		end
	end

	assign result_valid = res_valid_q;
	assign parsed_ok    = res_ok_q;
	assign address      = res_addr_q;

	// a failed parse always reports a zero address
	`IPV4P_ASSERT_SAME(a_fail_zero_addr, res_valid_q && !res_ok_q, res_addr_q == 32'd0)
	// the terminator leaves the parser in its reset state
	`IPV4P_ASSERT_NEXT(a_term_resets, proc && is_term,
		state_q.parse_phase == ipv4p_pkg::PH_START && state_q.part_count == 2'd0)
	// input is held only because of a waiting result
	`IPV4P_ASSERT_SAME(a_stall_cause, char_stall, res_valid_q && result_stall && is_term)
	// a fresh part always starts from zero
	`IPV4P_ASSERT_SAME(a_start_clear, state_q.parse_phase == ipv4p_pkg::PH_START,
		state_q.running_value == 32'd0)

endmodule
